@@ rtl/rlerd_pkg.sv @@
package rlerd_pkg;

  localparam int WORD_W     = 16;
  localparam int RUN_W      = 15;
  localparam int GATE_W     = 11;
  localparam int VAL_W      = 32;
  localparam int SCALE_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = VAL_W + SCALE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int MAX_GATE_COUNT_DEF = 1024;

  // Header word that closes a ray
  localparam logic [WORD_W-1:0] END_WORD = 16'h0001;

  localparam logic [VAL_W-1:0] BAD_GATE_Q16 = 32'h8000_0000;
  localparam logic [VAL_W-1:0] POS_SAT_Q16  = 32'h7FFF_FFFF;
  localparam logic [PROD_W-1:0] ROUND_HALF  = PROD_W'(64'h8000);

  // Register reset values
  localparam logic                  RST_COMPRESSED = 1'b1;
  localparam logic signed [WORD_W-1:0] RST_BAD_VALUE = 16'sh8000;
  localparam logic [GATE_W-1:0]     RST_GATE_LIMIT = 11'd1024;
  localparam logic signed [VAL_W-1:0] RST_OFFSET   = '0;
  localparam logic [SCALE_W-1:0]    RST_INV_SCALE  = 32'h0001_0000;

  typedef enum logic {
    PH_HEADER,
    PH_LITERAL
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COMPRESSED_MODE = 3'd0,
    CFG_BAD_VALUE       = 3'd1,
    CFG_GATE_LIMIT      = 3'd2,
    CFG_OFFSET          = 3'd3,
    CFG_INV_SCALE       = 3'd4
  } cfg_idx_t;

  // Everything a result carries besides the scaled value
  typedef struct packed {
    logic              use_scale;
    logic              fixed_bad;
    logic [GATE_W-1:0] repeat_count;
    logic              end_of_ray;
    logic              overflow_error;
    logic [GATE_W-1:0] gate_count;
  } rlerd_meta_t;

  typedef struct packed {
    logic [VAL_W-1:0]  gate_value;
    logic [GATE_W-1:0] repeat_count;
    logic              is_bad;
    logic              end_of_ray;
    logic              overflow_error;
    logic [GATE_W-1:0] gate_count;
  } rlerd_result_t;

endpackage

@@ rtl/rlerd_in_if.sv @@
interface rlerd_in_if import rlerd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] code_word;

  modport source(output valid, output code_word, input ready);
  modport sink(input valid, input code_word, output ready);
endinterface

@@ rtl/rlerd_out_if.sv @@
interface rlerd_out_if import rlerd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] gate_value;
  logic [GATE_W-1:0]       repeat_count;
  logic                    is_bad;
  logic                    end_of_ray;
  logic                    overflow_error;
  logic [GATE_W-1:0]       gate_count;

  modport source(output valid, output gate_value, output repeat_count, output is_bad,
                 output end_of_ray, output overflow_error, output gate_count,
                 input ready);
  modport sink(input valid, input gate_value, input repeat_count, input is_bad,
               input end_of_ray, input overflow_error, input gate_count,
               output ready);
endinterface

@@ rtl/rlerd_cfg_if.sv @@
interface rlerd_cfg_if import rlerd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

@@ rtl/rlerd_scale_pipe.sv @@
module rlerd_scale_pipe import rlerd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [WORD_W-1:0]         in_word,
  input  rlerd_meta_t               in_meta,
  input  logic signed [WORD_W-1:0]  bad_value,
  input  logic signed [VAL_W-1:0]   offset_q16,
  input  logic [SCALE_W-1:0]        inv_scale_q16,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rlerd_result_t             out_res
);

  // Stage 1: raw word; stage 2: magnitude; stage 3: product; then result register
  logic v1_r, v2_r, v3_r, vo_r;
  logic rdy1, rdy2, rdy3, rdyo;

  logic [WORD_W-1:0] word1_r;
  rlerd_meta_t       meta1_r, meta2_r, meta3_r;
  logic [VAL_W-1:0]  mag2_r, mag2_nxt;
  logic              neg2_r, neg2_nxt, neg3_r;
  logic              bad2_r, bad2_nxt, bad3_r;
  logic [PROD_W-1:0] prod3_r, prod3_nxt;
  rlerd_result_t     res_r, res_nxt;

  logic signed [VAL_W:0] word_ext, off_ext, diff_pos, diff_neg;
  logic [PROD_W-1:0]       rounded;
  logic [PROD_W-FRAC_W-1:0] mag_q16;
  logic [VAL_W-1:0]        scaled;

  assign rdyo     = !vo_r || out_ready;
  assign rdy3     = !v3_r || rdyo;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // Offset subtract; both directions in parallel, pick by sign
  always_comb begin
    word_ext = {{(VAL_W+1-WORD_W-FRAC_W){word1_r[WORD_W-1]}}, word1_r, {FRAC_W{1'b0}}};
    off_ext  = {offset_q16[VAL_W-1], offset_q16};
    diff_pos = word_ext - off_ext;
    diff_neg = off_ext - word_ext;
    neg2_nxt = diff_pos[VAL_W];
    mag2_nxt = neg2_nxt ? diff_neg[VAL_W-1:0] : diff_pos[VAL_W-1:0];
    bad2_nxt = ($signed(word1_r) == bad_value);
  end

  assign prod3_nxt = PROD_W'(mag2_r) * PROD_W'(inv_scale_q16);

  // Round magnitude to nearest, ties away from zero, then saturate
  always_comb begin
    rounded = prod3_r + ROUND_HALF;
    mag_q16 = rounded[PROD_W-1:FRAC_W];
    if (neg3_r) begin
      if (mag_q16 >= (PROD_W-FRAC_W)'(BAD_GATE_Q16)) begin
        scaled = BAD_GATE_Q16;
      end else begin
        scaled = '0 - mag_q16[VAL_W-1:0];
      end
    end else if (mag_q16 > (PROD_W-FRAC_W)'(POS_SAT_Q16)) begin
      scaled = POS_SAT_Q16;
    end else begin
      scaled = mag_q16[VAL_W-1:0];
    end
  end

  always_comb begin
    res_nxt.repeat_count   = meta3_r.repeat_count;
    res_nxt.end_of_ray     = meta3_r.end_of_ray;
    res_nxt.overflow_error = meta3_r.overflow_error;
    res_nxt.gate_count     = meta3_r.gate_count;
    if (meta3_r.use_scale) begin
      res_nxt.is_bad     = bad3_r;
      res_nxt.gate_value = bad3_r ? BAD_GATE_Q16 : scaled;
    end else begin
      res_nxt.is_bad     = meta3_r.fixed_bad;
      res_nxt.gate_value = meta3_r.fixed_bad ? BAD_GATE_Q16 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdyo) vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      word1_r <= in_word;
      meta1_r <= in_meta;
    end
    if (rdy2) begin
      mag2_r  <= mag2_nxt;
      neg2_r  <= neg2_nxt;
      bad2_r  <= bad2_nxt;
      meta2_r <= meta1_r;
    end
    if (rdy3) begin
      prod3_r <= prod3_nxt;
      neg3_r  <= neg2_r;
      bad3_r  <= bad2_r;
      meta3_r <= meta2_r;
    end
    if (rdyo) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_res   = res_r;

endmodule

@@ rtl/hrd16_rle_ray_decoder_unit.sv @@
// Run-length ray decoder with fixed-point gate scaling.
//
// in_ch carries one 16-bit word of a ray record per beat: headers and literal
// gate words in compressed mode, plain gate words otherwise. out_ch carries at
// most one result beat per input beat: a literal gate, a run of bad gates, an
// end-of-ray marker or an overflow marker, in input order. cfg_ch writes the
// five setup registers; it is always ready and must only be used while the
// decoder is drained.
//
// Header decode and the ray tally update in the cycle a word is taken. The
// gate value then passes offset subtract, a 32x32 multiply and round/saturate,
// through the raw word, magnitude, product and result registers to out_ch.
// One input beat is taken every cycle unless out_ch back-pressure drops in_ch
// ready; a header that starts a literal group or has a zero count gives no result.
//
// Reset restores the register defaults, empties the pipeline and returns the
// decoder to waiting for a header with a zero tally. When out_ch stalls the
// result register holds; the stages behind it keep filling, and in_ch ready
// drops only once all four stages hold a result.
module hrd16_rle_ray_decoder_unit import rlerd_pkg::*; #(
  parameter int MAX_GATE_COUNT = MAX_GATE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rlerd_in_if.sink    in_ch,
  rlerd_out_if.source out_ch,
  rlerd_cfg_if.sink   cfg_ch
);

  // The limit register is GATE_W wide, so the cap never needs more
  localparam int unsigned LIM_MAX = (1 << GATE_W) - 1;
  localparam int unsigned LIM_CAP = (MAX_GATE_COUNT > LIM_MAX) ? LIM_MAX : MAX_GATE_COUNT;

  // Setup registers
  logic                       cfg_compressed_r;
  logic signed [WORD_W-1:0]   cfg_bad_value_r;
  logic [GATE_W-1:0]          cfg_gate_limit_r;
  logic signed [VAL_W-1:0]    cfg_offset_r;
  logic [SCALE_W-1:0]         cfg_inv_scale_r;

  // Ray state
  phase_t            phase_r, phase_nxt;
  logic [RUN_W-1:0]  lit_left_r, lit_left_nxt;
  logic [GATE_W-1:0] tally_r, tally_nxt;

  logic              accept;
  logic              pipe_ready;
  logic              emit;
  rlerd_meta_t       meta;
  rlerd_result_t     pipe_res;

  logic [GATE_W-1:0] eff_lim;
  logic [GATE_W:0]   tally_inc;
  logic              inc_end;
  logic [RUN_W-1:0]  run_n;
  logic [RUN_W:0]    run_sum;
  logic              over_run;
  logic              is_end_word;
  logic              is_literal_hdr;
  logic [RUN_W-1:0]  lit_dec;
  logic [RUN_W-1:0]  tally_ext;
  logic [GATE_W-1:0] lit_gc;

  // Configuration: always ready, drop writes beyond the register list
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_compressed_r <= RST_COMPRESSED;
      cfg_bad_value_r  <= RST_BAD_VALUE;
      cfg_gate_limit_r <= RST_GATE_LIMIT;
      cfg_offset_r     <= RST_OFFSET;
      cfg_inv_scale_r  <= RST_INV_SCALE;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_COMPRESSED_MODE: cfg_compressed_r <= cfg_ch.data[0];
        CFG_BAD_VALUE:       cfg_bad_value_r  <= cfg_ch.data[WORD_W-1:0];
        CFG_GATE_LIMIT:      cfg_gate_limit_r <= cfg_ch.data[GATE_W-1:0];
        CFG_OFFSET:          cfg_offset_r     <= cfg_ch.data[VAL_W-1:0];
        CFG_INV_SCALE:       cfg_inv_scale_r  <= cfg_ch.data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = pipe_ready;
  assign accept      = in_ch.valid && pipe_ready;

  // Shared decode terms
  assign eff_lim = (cfg_gate_limit_r > GATE_W'(LIM_CAP)) ? GATE_W'(LIM_CAP)
                                                         : cfg_gate_limit_r;
  assign tally_inc      = {1'b0, tally_r} + (GATE_W+1)'(1);
  assign inc_end        = tally_inc >= {1'b0, eff_lim};
  assign run_n          = in_ch.code_word[RUN_W-1:0];
  assign run_sum        = {1'b0, run_n} + (RUN_W+1)'(tally_r);
  assign over_run       = run_sum > (RUN_W+1)'(eff_lim);
  assign is_end_word    = in_ch.code_word == END_WORD;
  assign is_literal_hdr = in_ch.code_word[WORD_W-1];
  assign lit_dec        = (lit_left_r != '0) ? lit_left_r - RUN_W'(1) : '0;
  assign tally_ext      = RUN_W'(tally_r);
  // Gates of the ray up to this literal: tally minus what is still to come
  assign lit_gc         = (tally_ext >= lit_dec) ? GATE_W'(tally_ext - lit_dec) : '0;

  // Next ray state
  always_comb begin
    phase_nxt    = phase_r;
    lit_left_nxt = lit_left_r;
    tally_nxt    = tally_r;
    if (accept) begin
      if (!cfg_compressed_r) begin
        phase_nxt    = PH_HEADER;
        lit_left_nxt = '0;
        tally_nxt    = inc_end ? '0 : tally_inc[GATE_W-1:0];
      end else begin
        case (phase_r)
          PH_LITERAL: begin
            lit_left_nxt = lit_dec;
            phase_nxt    = (lit_dec != '0) ? PH_LITERAL : PH_HEADER;
          end
          PH_HEADER: begin
            if (is_end_word || over_run) begin
              tally_nxt    = '0;
              lit_left_nxt = '0;
            end else if (run_n != '0) begin
              tally_nxt = run_sum[GATE_W-1:0];
              if (is_literal_hdr) begin
                phase_nxt    = PH_LITERAL;
                lit_left_nxt = run_n;
              end
            end
          end
          default: phase_nxt = PH_HEADER;
        endcase
      end
    end
  end

  // Result selection for the accepted word
  always_comb begin
    emit = 1'b0;
    meta = '0;
    if (!cfg_compressed_r) begin
      emit              = 1'b1;
      meta.use_scale    = 1'b1;
      meta.repeat_count = GATE_W'(1);
      meta.end_of_ray   = inc_end;
      meta.gate_count   = tally_inc[GATE_W-1:0];
    end else begin
      case (phase_r)
        PH_LITERAL: begin
          emit              = 1'b1;
          meta.use_scale    = 1'b1;
          meta.repeat_count = GATE_W'(1);
          meta.gate_count   = lit_gc;
        end
        PH_HEADER: begin
          if (is_end_word) begin
            emit            = 1'b1;
            meta.end_of_ray = 1'b1;
            meta.gate_count = tally_r;
          end else if (over_run) begin
            emit                = 1'b1;
            meta.end_of_ray     = 1'b1;
            meta.overflow_error = 1'b1;
            meta.gate_count     = tally_r;
          end else if (run_n != '0 && !is_literal_hdr) begin
            // Run of missing gates: one beat stands for the whole run
            emit              = 1'b1;
            meta.fixed_bad    = 1'b1;
            meta.repeat_count = run_n[GATE_W-1:0];
            meta.gate_count   = run_sum[GATE_W-1:0];
          end
        end
        default: emit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      lit_left_r <= '0;
      tally_r    <= '0;
    end else begin
      phase_r    <= phase_nxt;
      lit_left_r <= lit_left_nxt;
      tally_r    <= tally_nxt;
    end
  end

  rlerd_scale_pipe u_scale (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (accept && emit),
    .in_ready      (pipe_ready),
    .in_word       (in_ch.code_word),
    .in_meta       (meta),
    .bad_value     (cfg_bad_value_r),
    .offset_q16    (cfg_offset_r),
    .inv_scale_q16 (cfg_inv_scale_r),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_res       (pipe_res)
  );

  assign out_ch.gate_value     = pipe_res.gate_value;
  assign out_ch.repeat_count   = pipe_res.repeat_count;
  assign out_ch.is_bad         = pipe_res.is_bad;
  assign out_ch.end_of_ray     = pipe_res.end_of_ray;
  assign out_ch.overflow_error = pipe_res.overflow_error;
  assign out_ch.gate_count     = pipe_res.gate_count;

endmodule
